[hw/rtl/cwam_pkg.sv]
// Shared widths, codes, reset values and the front-to-back work entry type.
package cwam_pkg;

   localparam int CHAN_W = 3;
   localparam int SLOT_COUNT = 1 << CHAN_W;
   localparam int MASK_W = 8;
   localparam int KIND_W = 4;
   localparam int DATA_W = 32;
   localparam int GAIN_W = 24;
   localparam int FRAC_W = 16;
   localparam int PROD_W = DATA_W + GAIN_W;
   localparam int QUOT_W = PROD_W - FRAC_W;
   localparam int SUM_W = QUOT_W + 1;
   localparam int DEFAULT_CHANNELS = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Item kinds on the request channel
   localparam logic [KIND_W-1:0] KIND_SAMPLE     = 4'd0;
   localparam logic [KIND_W-1:0] KIND_GAIN       = 4'd1;
   localparam logic [KIND_W-1:0] KIND_OFFSET     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_HIGH       = 4'd3;
   localparam logic [KIND_W-1:0] KIND_LOW        = 4'd4;
   localparam logic [KIND_W-1:0] KIND_ARM        = 4'd5;
   localparam logic [KIND_W-1:0] KIND_DISARM     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ACK        = 4'd7;
   localparam logic [KIND_W-1:0] KIND_DISARM_ALL = 4'd8;

   // Operations handed from front to back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 3'd1;
   localparam logic [OP_W-1:0] OP_ARM    = 3'd2;
   localparam logic [OP_W-1:0] OP_DISARM = 3'd3;
   localparam logic [OP_W-1:0] OP_ACK    = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sd65536;
   localparam logic signed [DATA_W-1:0] GAIN_MAX = 32'sd8388607;
   localparam logic signed [DATA_W-1:0] GAIN_MIN = -32'sd8388608;
   localparam logic signed [DATA_W-1:0] HIGH_RESET = 32'sd327680;
   localparam logic signed [DATA_W-1:0] LOW_RESET = -32'sd327680;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(33'sh0_8000_0000));

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [CHAN_W-1:0]        channel;
      logic [MASK_W-1:0]        mask;
      logic signed [PROD_W-1:0] product;
      logic signed [DATA_W-1:0] offset;
      logic signed [DATA_W-1:0] high;
      logic signed [DATA_W-1:0] low;
   } work_type;

endpackage

[hw/rtl/cwam_if.sv]
// Valid/ready channel interfaces for request and response beats.
interface cwam_req_if
   import cwam_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [CHAN_W-1:0]        channel;
   logic signed [DATA_W-1:0] value;
   logic [MASK_W-1:0]        channel_mask;

   modport source (output valid, kind, channel, value, channel_mask, input ready);
   modport sink (input valid, kind, channel, value, channel_mask, output ready);
endinterface

interface cwam_rsp_if
   import cwam_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CHAN_W-1:0]        out_channel;
   logic signed [DATA_W-1:0] calibrated;
   logic                     out_of_window;
   logic [MASK_W-1:0]        active_flags;
   logic                     alarm_raised;
   logic                     alarm_cleared;

   modport source (output valid, out_channel, calibrated, out_of_window, active_flags,
                   alarm_raised, alarm_cleared, input ready);
   modport sink (input valid, out_channel, calibrated, out_of_window, active_flags,
                 alarm_raised, alarm_cleared, output ready);
endinterface

[hw/rtl/calibrated_window_alarm_monitor_unit.sv]
// Multichannel calibrated window alarm monitor. One request beat gives one
// response beat. A sample beat is scaled by its channel's Q8.16 gain, offset
// and saturated to Q16.16, then checked against the channel's alarm window;
// other beats load gain, offset and window tables or arm, disarm and
// acknowledge alarms. A new request is taken every cycle while the queue
// has room: the front end reads the tables and multiplies in the accepting
// cycle, a two-entry queue holds the product, and the back end adds,
// compares, updates the alarm flags and registers the response; a stalled
// response side fills the queue and then holds off requests.
module calibrated_window_alarm_monitor_unit
   import cwam_pkg::*;
   #(
   parameter int CHANNELS = DEFAULT_CHANNELS
   ) (
   input  logic       clock,
   input  logic       reset,
   cwam_req_if.sink   req_bus,
   cwam_rsp_if.source rsp_bus
);

   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   work_type q_entry;
   work_type q_head;

   cwam_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   cwam_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   cwam_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

[hw/rtl/cwam_front.sv]
// Front end: accepts request beats, owns the calibration tables, multiplies.
module cwam_front
   import cwam_pkg::*;
   #(
   parameter int CHANNELS = DEFAULT_CHANNELS
   ) (
   input  logic       clock,
   input  logic       reset,
   cwam_req_if.sink   req_bus,
   input  logic       q_full,
   output logic       q_push,
   output work_type   q_entry
);

   logic signed [GAIN_W-1:0] gain_ff [SLOT_COUNT];
   logic signed [DATA_W-1:0] offset_ff [SLOT_COUNT];
   logic signed [DATA_W-1:0] high_ff [SLOT_COUNT];
   logic signed [DATA_W-1:0] low_ff [SLOT_COUNT];

   logic                     accept;
   logic                     ch_ok;
   logic [MASK_W-1:0]        live_mask;
   logic signed [GAIN_W-1:0] gain_sat;
   logic signed [PROD_W-1:0] product;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;
   assign q_push = accept;
   assign ch_ok = int'(req_bus.channel) < CHANNELS;

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         live_mask[i] = i < CHANNELS;
      end
   end

   always_comb begin
      if (req_bus.value > GAIN_MAX) begin
         gain_sat = GAIN_W'(GAIN_MAX);
      end else if (req_bus.value < GAIN_MIN) begin
         gain_sat = GAIN_W'(GAIN_MIN);
      end else begin
         gain_sat = GAIN_W'(req_bus.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            gain_ff[i] <= GAIN_ONE;
            offset_ff[i] <= '0;
            high_ff[i] <= HIGH_RESET;
            low_ff[i] <= LOW_RESET;
         end
      end else if (accept && ch_ok) begin
         case (req_bus.kind)
            KIND_GAIN: gain_ff[req_bus.channel] <= gain_sat;
            KIND_OFFSET: offset_ff[req_bus.channel] <= req_bus.value;
            KIND_HIGH: high_ff[req_bus.channel] <= req_bus.value;
            KIND_LOW: low_ff[req_bus.channel] <= req_bus.value;
            default: ;
         endcase
      end
   end

   // Gain is Q8.16 and sample Q16.16: full product carries 32 fraction bits
   assign product = PROD_W'(gain_ff[req_bus.channel]) * PROD_W'(req_bus.value);

   always_comb begin
      q_entry.channel = req_bus.channel;
      q_entry.mask = req_bus.channel_mask & live_mask;
      q_entry.product = product;
      q_entry.offset = offset_ff[req_bus.channel];
      q_entry.high = high_ff[req_bus.channel];
      q_entry.low = low_ff[req_bus.channel];
      case (req_bus.kind)
         KIND_SAMPLE: q_entry.op = ch_ok ? OP_SAMPLE : OP_NONE;
         KIND_ARM: q_entry.op = OP_ARM;
         KIND_DISARM: q_entry.op = OP_DISARM;
         KIND_ACK: q_entry.op = OP_ACK;
         KIND_DISARM_ALL: q_entry.op = OP_CLEAR;
         default: q_entry.op = OP_NONE;
      endcase
   end

endmodule

[hw/rtl/cwam_queue.sv]
// Short FIFO of work entries between front and back.
module cwam_queue
   import cwam_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_entry,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output work_type head
);

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hw/rtl/cwam_back.sv]
// Back end: offset add, saturation, window test, alarm flags, response register.
module cwam_back
   import cwam_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type head,
   output logic     q_pop,
   cwam_rsp_if.source rsp_bus
);

   logic [MASK_W-1:0]        armed_ff, armed_in;
   logic [MASK_W-1:0]        latched_ff, latched_in;
   logic                     rsp_valid_ff;
   logic [CHAN_W-1:0]        out_channel_ff;
   logic signed [DATA_W-1:0] calibrated_ff, calibrated_in;
   logic                     oow_ff, oow_in;
   logic                     raised_ff, raised_in;
   logic                     cleared_ff, cleared_in;

   logic signed [QUOT_W-1:0] quot;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DATA_W-1:0] cal;
   logic                     outside;
   logic [MASK_W-1:0]        ch_bit;

   // Advance when the output register is free or being drained
   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_bus.ready);

   // Arithmetic shift floors, matching rounding toward minus infinity
   assign quot = QUOT_W'(head.product >>> FRAC_W);
   assign sum = SUM_W'(quot) + SUM_W'(head.offset);

   always_comb begin
      if (sum > SUM_MAX) begin
         cal = DATA_W'(SUM_MAX);
      end else if (sum < SUM_MIN) begin
         cal = DATA_W'(SUM_MIN);
      end else begin
         cal = DATA_W'(sum);
      end
   end

   // Inverted window keeps the legacy test when high does not exceed low
   assign outside = (head.high > head.low) ? ((cal > head.high) || (cal < head.low))
                                           : ((cal < head.high) || (cal > head.low));
   assign ch_bit = MASK_W'(1) << head.channel;

   always_comb begin
      armed_in = armed_ff;
      latched_in = latched_ff;
      calibrated_in = '0;
      oow_in = 1'b0;
      raised_in = 1'b0;
      cleared_in = 1'b0;
      case (head.op)
         OP_SAMPLE: begin
            calibrated_in = cal;
            oow_in = outside;
            if (outside) begin
               if ((armed_ff & ch_bit) != '0) begin
                  latched_in = latched_ff | ch_bit;
                  raised_in = 1'b1;
               end
            end else if ((latched_ff & ch_bit) != '0) begin
               latched_in = latched_ff & ~ch_bit;
               cleared_in = 1'b1;
            end
         end
         OP_ARM: armed_in = armed_ff | head.mask;
         OP_DISARM: armed_in = armed_ff & ~head.mask;
         OP_ACK: begin
            armed_in = armed_ff & ~latched_ff;
            latched_in = '0;
         end
         OP_CLEAR: begin
            armed_in = '0;
            latched_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         latched_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            armed_ff <= armed_in;
            latched_ff <= latched_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_channel_ff <= head.channel;
         calibrated_ff <= calibrated_in;
         oow_ff <= oow_in;
         raised_ff <= raised_in;
         cleared_ff <= cleared_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_channel = out_channel_ff;
   assign rsp_bus.calibrated = calibrated_ff;
   assign rsp_bus.out_of_window = oow_ff;
   assign rsp_bus.active_flags = latched_ff;
   assign rsp_bus.alarm_raised = raised_ff;
   assign rsp_bus.alarm_cleared = cleared_ff;

endmodule
